// File: rtl/core/y2r_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2r_pkg
// Shared constants and types for the 4:2:0 block to RGB color converter.
// ----------------------------------------------------------------------------
package y2r_pkg;

    // Widths of the datapath
    localparam int BYTE_W   = 8;
    localparam int CHROMA_W = 9;   // chroma with offset removed, signed
    localparam int TERM_W   = 25;  // scaled chroma terms, signed
    localparam int SUM_W    = 27;  // chroma term plus scaled luma, signed
    localparam int PIX_W    = 24;

    // 16.16 fixed-point color constants
    localparam logic signed [TERM_W-1:0] RV_SCALE = 25'sd91881;
    localparam logic signed [TERM_W-1:0] GU_SCALE = -25'sd22553;
    localparam logic signed [TERM_W-1:0] GV_SCALE = -25'sd46801;
    localparam logic signed [TERM_W-1:0] BU_SCALE = 25'sd116129;
    localparam logic signed [CHROMA_W-1:0] CHROMA_OFFSET = 9'sd128;

    // Clip thresholds
    localparam logic signed [SUM_W-1:0] CLIP_HIGH = 27'sd16777215;
    localparam logic signed [SUM_W-1:0] CLIP_LOW  = 27'sd65535;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_OUTPUT_MODE = 1'b0,
        CFG_SWAP_CHROMA = 1'b1
    } t_cfg_index;

    // Output packing modes
    typedef enum logic [0:0] {
        MODE_RGB888 = 1'b0,
        MODE_RGB565 = 1'b1
    } t_out_mode;

    // Stage load enables handed to each pixel slice
    typedef struct packed {
        logic load_clip;
        logic load_pack;
    } t_pix_ctl;

endpackage

// File: rtl/core/yuv420_block_to_rgb_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv420_block_to_rgb_unit
// Color conversion of one 2x2 block of 4:2:0 video to four RGB pixels.
// ----------------------------------------------------------------------------
// The unit takes one 2x2 luma block with its shared Cb and Cr bytes per
// request and returns the four converted pixels. It is a five-stage
// pipeline (offset removal, chroma multiply, term select and green sum,
// luma add and clip, pack), so one block enters every cycle and one
// leaves every cycle as long as the output side takes it; a stall on
// the output backs up the pipeline without losing or repeating a block.
// Write output_mode and swap_chroma_order only while the pipeline is empty.
// ----------------------------------------------------------------------------
module yuv420_block_to_rgb_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [0:0]  i_cfg_data,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // luma_top_left[7:0], luma_top_right[15:8], luma_bottom_left[23:16],
    // luma_bottom_right[31:24], chroma_blue[39:32], chroma_red[47:40]
    input  logic [47:0] s_axis_tdata,
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pixel_top_left[23:0], pixel_top_right[47:24], pixel_bottom_left[71:48],
    // pixel_bottom_right[95:72]
    output logic [95:0] m_axis_tdata
);
    import y2r_pkg::*;

    localparam int NUM_PIX = 4;

    // Configuration registers
    t_out_mode r_output_mode;
    logic      r_swap_chroma;

    // Stage valid bits and ready chain
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic c_rdy1, c_rdy2, c_rdy3, c_rdy4, c_rdy5;

    // Stage 1: luma and offset-free chroma
    logic [BYTE_W-1:0]          r1_luma [NUM_PIX];
    logic signed [CHROMA_W-1:0] r1_cb;
    logic signed [CHROMA_W-1:0] r1_cr;

    // Stage 2: chroma products
    logic [BYTE_W-1:0]          r2_luma [NUM_PIX];
    logic signed [TERM_W-1:0]   c_cb_ext;
    logic signed [TERM_W-1:0]   c_cr_ext;
    logic signed [TERM_W-1:0]   r2_cr_term;
    logic signed [TERM_W-1:0]   r2_cb_term;
    logic signed [TERM_W-1:0]   r2_gu_term;
    logic signed [TERM_W-1:0]   r2_gv_term;

    // Stage 3: selected first, green and third terms
    logic [BYTE_W-1:0]          r3_luma [NUM_PIX];
    logic signed [TERM_W-1:0]   r3_first;
    logic signed [TERM_W-1:0]   r3_green;
    logic signed [TERM_W-1:0]   r3_third;

    t_pix_ctl          c_pix_ctl;
    logic [PIX_W-1:0]  c_pixel [NUM_PIX];

    // Take configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_mode <= MODE_RGB888;
            r_swap_chroma <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_OUTPUT_MODE: r_output_mode <= t_out_mode'(i_cfg_data);
                CFG_SWAP_CHROMA: r_swap_chroma <= i_cfg_data[0];
                default:         r_swap_chroma <= r_swap_chroma;
            endcase
        end
    end

    // A stage advances when it is empty or the next one advances
    assign c_rdy5 = !r_v5 || m_axis_tready;
    assign c_rdy4 = !r_v4 || c_rdy5;
    assign c_rdy3 = !r_v3 || c_rdy4;
    assign c_rdy2 = !r_v2 || c_rdy3;
    assign c_rdy1 = !r_v1 || c_rdy2;
    assign s_axis_tready = c_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (c_rdy1) r_v1 <= s_axis_tvalid;
            if (c_rdy2) r_v2 <= r_v1;
            if (c_rdy3) r_v3 <= r_v2;
            if (c_rdy4) r_v4 <= r_v3;
            if (c_rdy5) r_v5 <= r_v4;
        end
    end

    // Stage 1: capture the request and drop the chroma offset
    always_ff @(posedge i_clk) begin
        if (c_rdy1) begin
            for (int k = 0; k < NUM_PIX; k++) begin
                r1_luma[k] <= s_axis_tdata[k*BYTE_W +: BYTE_W];
            end
            r1_cb <= $signed({1'b0, s_axis_tdata[39:32]}) - CHROMA_OFFSET;
            r1_cr <= $signed({1'b0, s_axis_tdata[47:40]}) - CHROMA_OFFSET;
        end
    end

    // Stage 2: scale chroma by the fixed-point constants
    assign c_cb_ext = $signed({{(TERM_W-CHROMA_W){r1_cb[CHROMA_W-1]}}, r1_cb});
    assign c_cr_ext = $signed({{(TERM_W-CHROMA_W){r1_cr[CHROMA_W-1]}}, r1_cr});

    always_ff @(posedge i_clk) begin
        if (c_rdy2) begin
            r2_luma    <= r1_luma;
            r2_cr_term <= c_cr_ext * RV_SCALE;
            r2_cb_term <= c_cb_ext * BU_SCALE;
            r2_gu_term <= c_cb_ext * GU_SCALE;
            r2_gv_term <= c_cr_ext * GV_SCALE;
        end
    end

    // Stage 3: sum the green term and order red and blue
    always_ff @(posedge i_clk) begin
        if (c_rdy3) begin
            r3_luma  <= r2_luma;
            r3_green <= r2_gu_term + r2_gv_term;
            if (r_swap_chroma) begin
                r3_first <= r2_cr_term;
                r3_third <= r2_cb_term;
            end else begin
                r3_first <= r2_cb_term;
                r3_third <= r2_cr_term;
            end
        end
    end

    // Stages 4 and 5: per-pixel clip and pack
    assign c_pix_ctl.load_clip = c_rdy4;
    assign c_pix_ctl.load_pack = c_rdy5;

    for (genvar p = 0; p < NUM_PIX; p++) begin : g_pix
        y2r_pixel u_pixel (
            .i_clk   (i_clk),
            .i_ctl   (c_pix_ctl),
            .i_mode  (r_output_mode),
            .i_luma  (r3_luma[p]),
            .i_first (r3_first),
            .i_green (r3_green),
            .i_third (r3_third),
            .o_pixel (c_pixel[p])
        );
        assign m_axis_tdata[p*PIX_W +: PIX_W] = c_pixel[p];
    end

    assign m_axis_tvalid = r_v5;

`ifndef SYNTHESIS
    // An empty pipeline always takes a request
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_v1 || r_v2 || r_v3 || r_v4 || r_v5) |-> s_axis_tready)
        else $error("empty pipeline refused a request");

    // A ready output side lets the whole pipeline advance
    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("ready chain broken with output ready");

    // RGB565 leaves the top byte of every pixel clear
    a_565_top_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_output_mode == MODE_RGB565)) |->
            (m_axis_tdata[23:16] == 8'h00) && (m_axis_tdata[47:40] == 8'h00) &&
            (m_axis_tdata[71:64] == 8'h00) && (m_axis_tdata[95:88] == 8'h00))
        else $error("RGB565 pixel has nonzero top byte");
`endif

endmodule

// File: rtl/core/y2r_pixel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2r_pixel
// One pixel slice: adds scaled luma to the three chroma terms, clips each
// sum to a byte, then packs the bytes as RGB888 or RGB565.
// ----------------------------------------------------------------------------
module y2r_pixel (
    input  logic                                 i_clk,
    input  y2r_pkg::t_pix_ctl                    i_ctl,
    input  y2r_pkg::t_out_mode                   i_mode,
    input  logic [y2r_pkg::BYTE_W-1:0]           i_luma,
    input  logic signed [y2r_pkg::TERM_W-1:0]    i_first,
    input  logic signed [y2r_pkg::TERM_W-1:0]    i_green,
    input  logic signed [y2r_pkg::TERM_W-1:0]    i_third,
    output logic [y2r_pkg::PIX_W-1:0]            o_pixel
);
    import y2r_pkg::*;

    logic signed [SUM_W-1:0] c_luma_term;
    logic signed [SUM_W-1:0] c_sum_first;
    logic signed [SUM_W-1:0] c_sum_green;
    logic signed [SUM_W-1:0] c_sum_third;
    logic [BYTE_W-1:0]       n_first;
    logic [BYTE_W-1:0]       n_green;
    logic [BYTE_W-1:0]       n_third;
    logic [BYTE_W-1:0]       r_first;
    logic [BYTE_W-1:0]       r_green;
    logic [BYTE_W-1:0]       r_third;
    logic [PIX_W-1:0]        n_pixel;
    logic [PIX_W-1:0]        r_pixel;

    function automatic logic [BYTE_W-1:0] clip_byte(input logic signed [SUM_W-1:0] s);
        logic [BYTE_W-1:0] b;
        if (s > CLIP_HIGH) begin
            b = 8'hFF;
        end else if (s <= CLIP_LOW) begin
            b = 8'h00;
        end else begin
            b = s[23:16];
        end
        return b;
    endfunction

    // Luma scaled by 65536 is a shift
    assign c_luma_term = $signed({3'b000, i_luma, 16'h0000});

    // Add and clip each channel
    always_comb begin
        c_sum_first = $signed({{(SUM_W-TERM_W){i_first[TERM_W-1]}}, i_first}) + c_luma_term;
        c_sum_green = $signed({{(SUM_W-TERM_W){i_green[TERM_W-1]}}, i_green}) + c_luma_term;
        c_sum_third = $signed({{(SUM_W-TERM_W){i_third[TERM_W-1]}}, i_third}) + c_luma_term;
        n_first     = clip_byte(c_sum_first);
        n_green     = clip_byte(c_sum_green);
        n_third     = clip_byte(c_sum_third);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_clip) begin
            r_first <= n_first;
            r_green <= n_green;
            r_third <= n_third;
        end
    end

    // Pack the clipped bytes
    always_comb begin
        unique case (i_mode)
            MODE_RGB565: n_pixel = {8'h00, r_third[7:3], r_green[7:5],
                                    r_green[4:2], r_first[7:3]};
            MODE_RGB888: n_pixel = {r_third, r_green, r_first};
            default:     n_pixel = {r_third, r_green, r_first};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_pack) begin
            r_pixel <= n_pixel;
        end
    end

    assign o_pixel = r_pixel;

endmodule

// File: sim/yuv420_block_to_rgb_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv420_block_to_rgb_unit_tb
// Self-checking bench for the 4:2:0 block to RGB color converter.
// ----------------------------------------------------------------------------
// A short directed table (neutral gray, black, white, chroma extremes,
// clipping on both ends, both packing modes and both chroma orders) is
// followed by random blocks in several register settings. Every request
// accepted on the input stream is queued as its typed expectation or its
// conversion by a bench-side color model. Each pixel group leaving the
// unit is compared pixel by pixel with the oldest queued entry. Both sides
// stall in random bursts; a watchdog ends a run that makes no progress.
// ----------------------------------------------------------------------------
module yuv420_block_to_rgb_unit_tb;
    import y2r_pkg::*;

    // Color constants in 16.16 fixed point
    localparam int SCALE_CR_RED   = 91881;
    localparam int SCALE_CB_GREEN = -22553;
    localparam int SCALE_CR_GREEN = -46801;
    localparam int SCALE_CB_BLUE  = 116129;
    localparam int LUMA_SCALE     = 65536;
    localparam int CHROMA_BIAS    = 128;

    localparam int PIPE_DEPTH   = 5;
    localparam int STALL_LIMIT  = 1000;
    localparam int MAX_REPORTS  = 100;
    localparam int SEG_COUNT    = 5;
    localparam int SEG_BLOCKS   = 130;

    typedef enum logic {
        ROW_BLOCK,
        ROW_WRITE
    } t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        logic [47:0] blk;
        logic        typed;
        logic [95:0] want;
        t_cfg_index  reg_idx;
        logic        reg_val;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    t_cfg_index  i_cfg_index;
    logic [0:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;

    // Typed expectation riding along with the current request
    logic        req_typed;
    logic [95:0] req_want;

    // Bench copy of the configuration
    t_out_mode   pix_mode  = MODE_RGB888;
    logic        cr_first  = 1'b1;

    logic [95:0] pixels_due [$];
    logic [95:0] due_px;
    t_stim_row   dir_rows [$];
    int          mismatch_count = 0;
    int          quiet_cycles   = 0;
    bit          quiet_tail     = 1'b0;

    string       pix_name [4] = '{"top_left", "top_right", "bottom_left", "bottom_right"};
    t_out_mode   seg_mode [SEG_COUNT] =
        '{MODE_RGB565, MODE_RGB888, MODE_RGB565, MODE_RGB888, MODE_RGB888};
    logic        seg_swap [SEG_COUNT] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1};

    yuv420_block_to_rgb_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Clip a 16.16 sum to one byte
    function automatic logic [7:0] clip_to_byte(input int s);
        if (s > 16777215) begin
            return 8'hFF;
        end
        if (s <= 65535) begin
            return 8'h00;
        end
        return s[23:16];
    endfunction

    // Pack three channel bytes as RGB888 or RGB565
    function automatic logic [23:0] pack_channels(input logic [7:0] f, input logic [7:0] g,
                                                  input logic [7:0] t, input t_out_mode mode);
        if (mode == MODE_RGB565) begin
            return {8'h00, t[7:3], g[7:5], g[4:2], f[7:3]};
        end
        return {t, g, f};
    endfunction

    // Convert one 2x2 block to its four pixels
    function automatic logic [95:0] convert_block(input logic [47:0] blk, input t_out_mode mode,
                                                  input logic crf);
        int cb;
        int cr;
        int cr_term;
        int cb_term;
        int green_term;
        int first;
        int third;
        int yterm;
        int k;
        logic [95:0] px;
        cb = blk[39:32];
        cb = cb - CHROMA_BIAS;
        cr = blk[47:40];
        cr = cr - CHROMA_BIAS;
        cr_term    = SCALE_CR_RED * cr;
        cb_term    = SCALE_CB_BLUE * cb;
        green_term = SCALE_CB_GREEN * cb + SCALE_CR_GREEN * cr;
        first = crf ? cr_term : cb_term;
        third = crf ? cb_term : cr_term;
        for (k = 0; k < 4; k++) begin
            yterm = blk[k*8 +: 8];
            yterm = yterm * LUMA_SCALE;
            px[k*24 +: 24] = pack_channels(clip_to_byte(first + yterm),
                                           clip_to_byte(green_term + yterm),
                                           clip_to_byte(third + yterm), mode);
        end
        return px;
    endfunction

    function automatic logic [47:0] pack_block(input logic [7:0] y0, input logic [7:0] y1,
                                               input logic [7:0] y2, input logic [7:0] y3,
                                               input logic [7:0] cb, input logic [7:0] cr);
        return {cr, cb, y3, y2, y1, y0};
    endfunction

    // Random block: mostly uniform, some near-neutral chroma, some extremes
    function automatic logic [47:0] random_block();
        logic [47:0] b;
        logic [31:0] w;
        int pick;
        int k;
        w = $urandom;
        b[31:0] = w;
        w = $urandom;
        b[47:32] = w[15:0];
        pick = $urandom_range(0, 19);
        if (pick < 3) begin
            b[39:32] = 8'd125 + 8'($urandom_range(0, 6));
            b[47:40] = 8'd125 + 8'($urandom_range(0, 6));
        end else if (pick < 6) begin
            for (k = 0; k < 6; k++) begin
                case ($urandom_range(0, 2))
                    0: b[k*8 +: 8] = 8'h00;
                    1: b[k*8 +: 8] = 8'hFF;
                    default: ;
                endcase
            end
        end
        return b;
    endfunction

    function automatic void add_block(input logic [47:0] blk, input logic typed,
                                      input logic [95:0] want);
        t_stim_row r;
        r.kind    = ROW_BLOCK;
        r.blk     = blk;
        r.typed   = typed;
        r.want    = want;
        r.reg_idx = CFG_OUTPUT_MODE;
        r.reg_val = 1'b0;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_write(input t_cfg_index idx, input logic val);
        t_stim_row r;
        r.kind    = ROW_WRITE;
        r.blk     = '0;
        r.typed   = 1'b0;
        r.want    = '0;
        r.reg_idx = idx;
        r.reg_val = val;
        dir_rows.push_back(r);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t ns: mismatch: %s", $time, msg);
        end
    endtask

    // Present one request and hold it until accepted, then maybe idle
    task automatic send_block(input logic [47:0] blk, input logic typed,
                              input logic [95:0] want);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= blk;
        req_typed     <= typed;
        req_want      <= want;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait until every queued pixel group has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pixels_due.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 2) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_index idx, input logic val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Output side: ready with random stall bursts, none in the tail
    initial begin
        m_axis_tready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (!quiet_tail && $urandom_range(0, 11) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Track register writes, queue expectations, check results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_OUTPUT_MODE: pix_mode = t_out_mode'(i_cfg_data);
                    CFG_SWAP_CHROMA: cr_first = i_cfg_data[0];
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                pixels_due.push_back(req_typed ? req_want
                                     : convert_block(s_axis_tdata, pix_mode, cr_first));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (pixels_due.size() == 0) begin
                    report_mismatch($sformatf("result %024h with nothing expected",
                                              m_axis_tdata));
                end else begin
                    due_px = pixels_due.pop_front();
                    for (int k = 0; k < 4; k++) begin
                        if (m_axis_tdata[k*24 +: 24] !== due_px[k*24 +: 24]) begin
                            report_mismatch($sformatf("%s got %06h want %06h", pix_name[k],
                                                      m_axis_tdata[k*24 +: 24],
                                                      due_px[k*24 +: 24]));
                        end
                    end
                end
            end
        end
    end

    // Watchdog: end the run after too many cycles without progress
    initial begin
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Stimulus
    initial begin : stimulus
        int        seg;
        int        n;
        int        r;
        t_out_mode mode;
        logic      swap;
        t_stim_row row;

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_OUTPUT_MODE;
        i_cfg_data    <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        req_typed     <= 1'b0;
        req_want      <= '0;

        // Reset settings: RGB888, Cr-based byte first
        add_block(pack_block(8'd0, 8'd0, 8'd0, 8'd0, 8'd128, 8'd128), 1'b1, '0);
        add_block(pack_block(8'd255, 8'd255, 8'd255, 8'd255, 8'd128, 8'd128), 1'b1,
                  {4{24'hFFFFFF}});
        add_block(pack_block(8'd0, 8'd255, 8'd255, 8'd0, 8'd128, 8'd128), 1'b1,
                  {24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'h000000});
        add_block(pack_block(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0), 1'b0, '0);
        add_block(pack_block(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255), 1'b0, '0);
        add_block(pack_block(8'd16, 8'd235, 8'd128, 8'd64, 8'd0, 8'd255), 1'b0, '0);
        add_block(pack_block(8'd16, 8'd235, 8'd128, 8'd64, 8'd255, 8'd0), 1'b0, '0);
        // Just off neutral chroma: clip at the low and the high end
        add_block(pack_block(8'd0, 8'd1, 8'd254, 8'd255, 8'd129, 8'd127), 1'b0, '0);
        add_block(pack_block(8'd255, 8'd254, 8'd1, 8'd0, 8'd127, 8'd129), 1'b0, '0);
        // RGB565 packing
        add_write(CFG_OUTPUT_MODE, MODE_RGB565);
        add_block(pack_block(8'd255, 8'd255, 8'd255, 8'd255, 8'd128, 8'd128), 1'b1,
                  {4{24'h00FFFF}});
        add_block(pack_block(8'd0, 8'd0, 8'd0, 8'd0, 8'd128, 8'd128), 1'b1, '0);
        add_block(pack_block(8'd90, 8'd180, 8'd30, 8'd220, 8'd0, 8'd255), 1'b0, '0);
        add_block(pack_block(8'd200, 8'd100, 8'd50, 8'd10, 8'd255, 8'd0), 1'b0, '0);
        // Cb-based byte first
        add_write(CFG_SWAP_CHROMA, 1'b0);
        add_block(pack_block(8'd16, 8'd235, 8'd128, 8'd64, 8'd0, 8'd255), 1'b0, '0);
        add_block(pack_block(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd255), 1'b0, '0);
        add_block(pack_block(8'd255, 8'd255, 8'd255, 8'd255, 8'd128, 8'd128), 1'b1,
                  {4{24'h00FFFF}});
        add_write(CFG_OUTPUT_MODE, MODE_RGB888);
        add_block(pack_block(8'd16, 8'd235, 8'd128, 8'd64, 8'd0, 8'd255), 1'b0, '0);
        add_block(pack_block(8'd200, 8'd100, 8'd50, 8'd10, 8'd255, 8'd0), 1'b0, '0);
        add_block(pack_block(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0), 1'b0, '0);
        add_block(pack_block(8'd255, 8'd255, 8'd255, 8'd255, 8'd128, 8'd128), 1'b1,
                  {4{24'hFFFFFF}});
        add_write(CFG_SWAP_CHROMA, 1'b1);

        // Hold reset, then release it
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        for (r = 0; r < dir_rows.size(); r++) begin
            row = dir_rows[r];
            if (row.kind == ROW_WRITE) begin
                wait_drained();
                write_register(row.reg_idx, row.reg_val);
            end else begin
                send_block(row.blk, row.typed, row.want);
            end
        end

        // Random blocks, one register setting per segment
        for (seg = 0; seg < SEG_COUNT; seg++) begin
            wait_drained();
            mode = seg_mode[seg];
            swap = seg_swap[seg];
            if (seg == 3) begin
                mode = t_out_mode'($urandom_range(0, 1));
                swap = 1'($urandom_range(0, 1));
            end
            write_register(CFG_OUTPUT_MODE, mode);
            write_register(CFG_SWAP_CHROMA, swap);
            for (n = 0; n < SEG_BLOCKS; n++) begin
                if (seg == SEG_COUNT - 1 && n == 30) begin
                    quiet_tail = 1'b1;
                end
                // Hold the sender until the pipeline has emptied once mid-run
                if (seg == 2 && n == SEG_BLOCKS / 2) begin
                    wait_drained();
                end
                send_block(random_block(), 1'b0, '0);
            end
        end

        wait_drained();
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
